/* rtl/mgpv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mgpv_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 16;
  localparam int THR_W       = 15;
  localparam int PLEN_W      = 13;
  localparam int PEAK_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int FRAC_BITS   = 12;
  // signed sample times zero-extended gain
  localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;

  localparam int HISTORY_DEPTH_DEF = 10;
  localparam int MAX_PACKET_DEF    = 4096;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
  localparam logic [THR_W-1:0]  THR_RESET  = 15'd3277;
  localparam logic [PLEN_W-1:0] PLEN_RESET = 13'd2880;

  localparam logic [CFG_IDX_W-1:0] REG_MIC_GAIN       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_LENGTH  = 2'd2;

  localparam logic signed [PROD_W-1:0] SAT_MAX = 33'sd32767;
  localparam logic signed [PROD_W-1:0] SAT_MIN = -33'sd32768;
  localparam logic [PROD_W-1:0] FRAC_MASK = PROD_W'((1 << FRAC_BITS) - 1);

  typedef struct packed {
    logic              shift;
    logic [PEAK_W-1:0] thr;
  } cell_ctrl_t;

  // divide by 2^12 toward zero, then clamp to the signed sample range
  function automatic logic signed [SAMPLE_W-1:0] scale_sat(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] q;
    logic signed [SAMPLE_W-1:0] r;
    biased = p + (p[PROD_W-1] ? FRAC_MASK : '0);
    q = biased >>> FRAC_BITS;
    if (q > SAT_MAX) begin
      r = SAT_MAX[SAMPLE_W-1:0];
    end else if (q < SAT_MIN) begin
      r = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      r = q[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/mgpv_gain.sv */
`timescale 1ns / 1ps
`default_nettype none

module mgpv_gain (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic signed [mgpv_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic [mgpv_pkg::GAIN_W-1:0]           gain,
  output logic signed [mgpv_pkg::PROD_W-1:0]         prod
);
  import mgpv_pkg::*;

  logic signed [GAIN_W:0] gain_s;

  assign gain_s = $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(sample * gain_s);
    end
  end

endmodule

`default_nettype wire

/* rtl/mgpv_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module mgpv_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mgpv_pkg::cell_ctrl_t          ctrl,
  input  wire logic [mgpv_pkg::PEAK_W-1:0]   din,
  output logic [mgpv_pkg::PEAK_W-1:0]        q,
  output logic                               hit
);
  import mgpv_pkg::*;

  // hit reflects the value this cell holds after a shift
  assign hit = (din >= ctrl.thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (ctrl.shift) begin
      q <= din;
    end
  end

endmodule

`default_nettype wire

/* rtl/mic_gain_peak_voice_gate.sv */
// An accepted input item reaches its result through the product register and then the output register.
// Throughput: one item per cycle when the output is not stalled; gain multiply in the first
// stage, clamp, peak and the history cell row in the second.
// Reset (rst, synchronous): clears counter, running peak, history cells and voice flag,
// and restores gain 4096, threshold 3277, packet length 2880. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module mic_gain_peak_voice_gate #(
  parameter int HISTORY_DEPTH = mgpv_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_PACKET    = mgpv_pkg::MAX_PACKET_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [mgpv_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [mgpv_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [mgpv_pkg::SAMPLE_W-1:0]  mic_sample,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [mgpv_pkg::SAMPLE_W-1:0]       scaled_sample,
  output logic                                       packet_end,
  output logic [mgpv_pkg::PEAK_W-1:0]                packet_peak,
  output logic                                       voice_active
);
  import mgpv_pkg::*;

  localparam int CNT_W = (MAX_PACKET > 2) ? $clog2(MAX_PACKET) : 1;
  localparam int MAXL_W = $clog2(MAX_PACKET + 1);
  localparam int EW = (MAXL_W > PLEN_W) ? MAXL_W : PLEN_W;

  logic [GAIN_W-1:0] mic_gain;
  logic [THR_W-1:0]  peak_threshold;
  logic [PLEN_W-1:0] packet_length;

  logic                      s1_valid;
  logic                      s1_en;
  logic                      adv;
  logic signed [PROD_W-1:0]  prod;

  logic [CNT_W-1:0]  sample_counter;
  logic [PEAK_W-1:0] running_peak;
  logic              voice_flag;

  logic signed [SAMPLE_W-1:0] scaled;
  logic [PEAK_W-1:0]          mag;
  logic [PEAK_W-1:0]          peak_next;
  logic [EW-1:0]              eff_len;
  logic [EW-1:0]              taken;
  logic                       end_pkt;
  logic                       step;
  cell_ctrl_t                 ctrl;

  logic [PEAK_W-1:0]        hist_q [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] hits;

  // second stage moves whenever the output register is free or being drained
  assign adv      = !out_valid || !out_stall;
  assign s1_en    = !s1_valid || adv;
  assign in_stall = !s1_en;
  assign step     = adv && s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mic_gain       <= GAIN_RESET;
      peak_threshold <= THR_RESET;
      packet_length  <= PLEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIC_GAIN:       mic_gain       <= cfg_data[GAIN_W-1:0];
        REG_PEAK_THRESHOLD: peak_threshold <= cfg_data[THR_W-1:0];
        REG_PACKET_LENGTH:  packet_length  <= cfg_data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  mgpv_gain u_gain (
    .clk    (clk),
    .en     (s1_en),
    .sample (mic_sample),
    .gain   (mic_gain),
    .prod   (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_valid;
    end
  end

  always_comb begin
    scaled    = scale_sat(prod);
    mag       = scaled[SAMPLE_W-1] ? PEAK_W'(~scaled + 1'b1) : PEAK_W'(scaled);
    peak_next = (mag > running_peak) ? mag : running_peak;
    eff_len   = EW'(packet_length);
    if (eff_len == '0) begin
      eff_len = EW'(1);
    end
    if (eff_len > EW'(MAX_PACKET)) begin
      eff_len = EW'(MAX_PACKET);
    end
    taken   = EW'(sample_counter) + EW'(1);
    end_pkt = (taken >= eff_len);
    ctrl.shift = step && end_pkt;
    ctrl.thr   = (peak_threshold == '0) ? PEAK_W'(1) : PEAK_W'(peak_threshold);
  end

  genvar i;
  generate
    for (i = 0; i < HISTORY_DEPTH; i++) begin : g_hist
      logic [PEAK_W-1:0] din;
      if (i == HISTORY_DEPTH - 1) begin : g_last
        assign din = peak_next;
      end else begin : g_mid
        assign din = hist_q[i+1];
      end
      mgpv_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctrl (ctrl),
        .din  (din),
        .q    (hist_q[i]),
        .hit  (hits[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
      running_peak   <= '0;
      voice_flag     <= 1'b0;
    end else if (step) begin
      if (end_pkt) begin
        sample_counter <= '0;
        running_peak   <= '0;
        voice_flag     <= |hits;
      end else begin
        sample_counter <= taken[CNT_W-1:0];
        running_peak   <= peak_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      scaled_sample <= scaled;
      packet_end    <= end_pkt;
      packet_peak   <= end_pkt ? peak_next : '0;
      voice_active  <= end_pkt ? |hits : voice_flag;
    end
  end

endmodule

`default_nettype wire

/* rtl/mgpv_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module mgpv_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  in_stall,
  input wire logic                                  out_valid,
  input wire logic                                  out_stall,
  input wire logic signed [mgpv_pkg::SAMPLE_W-1:0]  scaled_sample,
  input wire logic                                  packet_end,
  input wire logic [mgpv_pkg::PEAK_W-1:0]           packet_peak
);
  import mgpv_pkg::*;

  logic [PEAK_W-1:0] out_mag;

  assign out_mag = scaled_sample[SAMPLE_W-1] ? PEAK_W'(~scaled_sample + 1'b1)
                                             : PEAK_W'(scaled_sample);

  // empty output register means the pipe can always take an item
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

  a_peak_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !packet_end) |-> (packet_peak == '0))
    else $error("packet_peak nonzero outside packet end");

  a_peak_covers: assert property (@(posedge clk) disable iff (rst)
    (out_valid && packet_end) |-> (packet_peak >= out_mag && packet_peak <= 16'd32768))
    else $error("packet peak below last sample magnitude or out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(scaled_sample)
                                  && $stable(packet_end) && $stable(packet_peak)))
    else $error("stalled result changed");

endmodule

bind mic_gain_peak_voice_gate mgpv_checker u_mgpv_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .scaled_sample (scaled_sample),
  .packet_end    (packet_end),
  .packet_peak   (packet_peak)
);

`default_nettype wire
